### hdl/eod_pkg.sv
// Shared constants, types and state codes for the energy onset detector.
// No dependencies; imported by every module of the block.
package eod_pkg;

	localparam int HOP_LEN    = 128;
	localparam int WINDOW_LEN = 1024;
	localparam int RING_LEN   = 2048;

	localparam int HOP_W    = $clog2(HOP_LEN);
	localparam int POS_W    = $clog2(RING_LEN);
	localparam int PEND_W   = $clog2(WINDOW_LEN);
	localparam int ENERGY_W = 31 + HOP_W;

	localparam int PEND_INIT_I = (WINDOW_LEN > 2 * HOP_LEN) ? (WINDOW_LEN - 2 * HOP_LEN) : 1;
	localparam logic [PEND_W-1:0] PEND_INIT = PEND_W'(PEND_INIT_I);
	localparam logic [POS_W-1:0]  ONSET_BACK = POS_W'(2 * HOP_LEN);

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 15;
	localparam int CFG_W    = 16;

	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int ROOT_W = 16;
	localparam int RAD_W  = 2 * ROOT_W;

	localparam logic [16:0] FLOOR_MIN = 17'd196;
	localparam logic [8:0]  SENS_MAX  = 9'd256;
	localparam logic [8:0]  ABS_Q8    = 9'd409;
	localparam logic [9:0]  REL_Q8    = 10'd563;
	localparam logic [8:0]  REL_SLOPE = 9'd307;
	localparam logic [15:0] ENV_KEEP  = 16'd27852;
	localparam logic [15:0] ENV_NEW   = 16'd4915;

	typedef enum logic [1:0] {
		REG_ENABLE      = 2'd0,
		REG_SENSITIVITY = 2'd1,
		REG_NOISE_FLOOR = 2'd2,
		REG_HOLDOFF     = 2'd3
	} reg_index_t;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_SQ   = 10'b00_0000_0010,
		ST_ACC  = 10'b00_0000_0100,
		ST_SQRT = 10'b00_0000_1000,
		ST_T1   = 10'b00_0001_0000,
		ST_T2   = 10'b00_0010_0000,
		ST_T3   = 10'b00_0100_0000,
		ST_E1   = 10'b00_1000_0000,
		ST_E2   = 10'b01_0000_0000,
		ST_FIN  = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_status_t;

endpackage

### hdl/eod_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on eod_pkg for operand widths and the operand struct.
module eod_mul (
	input  logic                    clk,
	input  eod_pkg::mul_op_t        op,
	output logic [eod_pkg::MUL_P_W-1:0] prod
);
	import eod_pkg::*;

	logic [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op.a) * MUL_P_W'(op.b);
	end

	assign prod = prod_q;

endmodule

### hdl/eod_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on eod_pkg for widths and the status struct.
module eod_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [eod_pkg::RAD_W-1:0]  radicand,
	output eod_pkg::sqrt_status_t      status,
	output logic [eod_pkg::ROOT_W-1:0] root
);
	import eod_pkg::*;

	localparam int REM_W = ROOT_W + 4;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign root        = root_q;

endmodule

### hdl/energy_onset_detector.sv
// Energy onset detector: sequencer, detection state and output register.
// Each sample passes IDLE, SQ, ACC and FIN; a sample that closes a hop also passes
// SQRT, T1, T2, T3, E1 and E2, waiting in SQRT on the 16-step square root.
// One sample is in work at a time; s_tready is low until the sequencer returns
// to IDLE, and FIN holds while the output word waits for m_tready.
// arst_n clears all detection state and loads the register defaults.
// Depends on eod_pkg, eod_mul and eod_isqrt.
module energy_onset_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [14:0] level, [25:15] window_start, [31:26] zero
	output logic [2:0]  m_tuser,   // [0] hop_done, [1] onset, [2] window_ready
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [eod_pkg::CFG_W-1:0] cfg_data
);
	import eod_pkg::*;

	state_t state_q;

	logic                en_q;
	logic [8:0]          sens_q;
	logic [14:0]         noise_q;
	logic [15:0]         holdcfg_q;

	logic [SAMPLE_W-1:0] mag_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [POS_W-1:0]    wpos_q;
	logic [HOP_W-1:0]    fill_q;
	logic [LEVEL_W-1:0]  env_q;
	logic [15:0]         hold_q;
	logic [PEND_W-1:0]   pend_q;
	logic                pact_q;
	logic [POS_W-1:0]    ostart_q;

	logic [LEVEL_W-1:0]  rms_q;
	logic                abs_ok_q;
	logic [MUL_P_W-1:0]  env_part_q;

	logic                hop_q;
	logic                onset_q;
	logic                ready_q;
	logic [POS_W-1:0]    wstart_q;

	logic                out_valid_q;
	logic [LEVEL_W-1:0]  out_level_q;
	logic [POS_W-1:0]    out_wstart_q;
	logic [2:0]          out_flags_q;

	mul_op_t             mop;
	logic [MUL_P_W-1:0]  prod;
	sqrt_status_t        sq_st;
	logic [ROOT_W-1:0]   sq_root;
	logic                sq_start;
	logic [RAD_W-1:0]    sq_in;

	logic                take;
	logic [SAMPLE_W-1:0] mag;
	logic [ENERGY_W-1:0] energy_sum;
	logic                hop_end;
	logic [PEND_W-1:0]   pend_dec;
	logic [8:0]          sens_cl;
	logic [16:0]         noise3;
	logic [16:0]         flr;
	logic [8:0]          abs_fac;
	logic [17:0]         slope_prod;
	logic [9:0]          ratio;
	logic [MUL_P_W-1:0]  lhs;
	logic                out_free;
	logic [MUL_P_W-1:0]  env_sum;

	assign s_tready = (state_q == ST_IDLE);
	assign take     = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		mag        = s_tdata[15] ? SAMPLE_W'(~s_tdata + 1'b1) : s_tdata;
		energy_sum = energy_q + ENERGY_W'(prod);
		hop_end    = (fill_q == HOP_W'(HOP_LEN - 1));
		pend_dec   = (pend_q != '0) ? pend_q - 1'b1 : pend_q;
		sq_start   = (state_q == ST_ACC) && hop_end;
		sq_in      = RAD_W'(energy_sum >> HOP_W);
		sens_cl    = (sens_q > SENS_MAX) ? SENS_MAX : sens_q;
		noise3     = {1'b0, noise_q, 1'b0} + 17'(noise_q);
		flr        = (noise3 < FLOOR_MIN) ? FLOOR_MIN : noise3;
		abs_fac    = ABS_Q8 - sens_cl;
		slope_prod = 18'(sens_cl) * 18'(REL_SLOPE);
		ratio      = REL_Q8 - slope_prod[17:8];
		lhs        = MUL_P_W'({rms_q, 8'b0});
		env_sum    = env_part_q + prod;
	end

	always_comb begin
		mop = '0;
		unique case (state_q)
			ST_SQ: begin
				mop.a = MUL_A_W'(mag_q);
				mop.b = mag_q;
			end
			ST_T1: begin
				mop.a = flr;
				mop.b = MUL_B_W'(abs_fac);
			end
			ST_T2: begin
				mop.a = MUL_A_W'(env_q);
				mop.b = MUL_B_W'(ratio);
			end
			ST_T3: begin
				mop.a = MUL_A_W'(env_q);
				mop.b = ENV_KEEP;
			end
			ST_E1: begin
				mop.a = MUL_A_W'(rms_q);
				mop.b = ENV_NEW;
			end
			default: mop = '0;
		endcase
	end

	eod_mul u_mul (
		.clk  (clk),
		.op   (mop),
		.prod (prod)
	);

	eod_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.status   (sq_st),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			sens_q    <= 9'd128;
			noise_q   <= '0;
			holdcfg_q <= 16'd25;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ENABLE:      en_q      <= cfg_data[0];
				REG_SENSITIVITY: sens_q    <= cfg_data[8:0];
				REG_NOISE_FLOOR: noise_q   <= cfg_data[14:0];
				REG_HOLDOFF:     holdcfg_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			energy_q <= '0;
			wpos_q   <= '0;
			fill_q   <= '0;
			env_q    <= '0;
			hold_q   <= '0;
			pend_q   <= '0;
			pact_q   <= 1'b0;
			ostart_q <= '0;
			hop_q    <= 1'b0;
			onset_q  <= 1'b0;
			ready_q  <= 1'b0;
			wstart_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						hop_q    <= 1'b0;
						onset_q  <= 1'b0;
						ready_q  <= 1'b0;
						wstart_q <= '0;
						state_q  <= ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_ACC;
				ST_ACC: begin
					wpos_q <= wpos_q + 1'b1;
					if (pact_q) begin
						pend_q <= pend_dec;
						if (pend_dec == '0) begin
							pact_q   <= 1'b0;
							ready_q  <= 1'b1;
							wstart_q <= ostart_q;
						end
					end
					if (hop_end) begin
						fill_q   <= '0;
						energy_q <= '0;
						hop_q    <= 1'b1;
						if (hold_q != '0) hold_q <= hold_q - 1'b1;
						state_q  <= ST_SQRT;
					end else begin
						fill_q   <= fill_q + 1'b1;
						energy_q <= energy_sum;
						state_q  <= ST_FIN;
					end
				end
				ST_SQRT: if (sq_st.done) state_q <= ST_T1;
				ST_T1: state_q <= ST_T2;
				ST_T2: state_q <= ST_T3;
				ST_T3: begin
					if (en_q && hold_q == '0 && !pact_q && abs_ok_q && lhs > prod) begin
						onset_q  <= 1'b1;
						ostart_q <= wpos_q - ONSET_BACK;
						pend_q   <= PEND_INIT;
						pact_q   <= 1'b1;
						hold_q   <= holdcfg_q;
					end
					state_q <= ST_E1;
				end
				ST_E1: state_q <= ST_E2;
				ST_E2: begin
					env_q   <= env_sum[LEVEL_W+14:15];
					state_q <= ST_FIN;
				end
				ST_FIN: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) mag_q <= mag;
		if (state_q == ST_SQRT && sq_st.done) begin
			rms_q <= sq_root[ROOT_W-1] ? '1 : sq_root[LEVEL_W-1:0];
		end
		if (state_q == ST_T2) abs_ok_q <= lhs > prod;
		if (state_q == ST_E1) env_part_q <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_level_q  <= hop_q ? rms_q : '0;
			out_wstart_q <= wstart_q;
			out_flags_q  <= {ready_q, onset_q, hop_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 32'({out_wstart_q, out_level_q});
	assign m_tuser  = out_flags_q;

`ifndef SYNTH
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_st.done |-> state_q == ST_SQRT)
		else $error("square root finished outside its wait state");

	a_pending_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pact_q |-> pend_q != '0)
		else $error("pending window active with an expired countdown");

	a_onset_on_hop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("onset reported on a word that closed no hop");

	a_sqrt_only_at_hop: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |=> sq_st.busy && hop_q)
		else $error("square root started without a closing hop");
`endif

endmodule
